// ===== rtl/core/lrbs_pkg.sv =====
// Package for the link retry backoff supervisor.
// Holds field widths, codes, record types and the backoff delay function.
// No dependencies; every other file imports it.
`default_nettype none

package lrbs_pkg;

   localparam int MODE_W    = 3;
   localparam int REASON_W  = 8;
   localparam int ADDR_W    = 32;
   localparam int COUNT_W   = 8;
   localparam int BASE_W    = 16;
   localparam int SHIFT_W   = 3;
   localparam int QUIET_W   = 24;
   localparam int SLICE_W   = 16;
   localparam int WAIT_W    = 32;
   localparam int DELAY_W   = 24;
   localparam int SECS_W    = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   // seconds = (remain * DIV_MUL) >> DIV_SHIFT, exact for any 24-bit remain
   localparam int DIV_SHIFT         = 34;
   localparam int MUL_W             = 25;
   localparam logic [MUL_W-1:0] DIV_MUL = 25'd17179870;
   localparam int PROD_W            = DELAY_W + MUL_W;

   localparam logic [BASE_W-1:0]  BASE_RESET  = 16'd30000;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd4;
   localparam logic [QUIET_W-1:0] QUIET_RESET = 24'd300000;
   localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd5000;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK      = 3'd0,
      MODE_WAKE      = 3'd1,
      MODE_AP_START  = 3'd2,
      MODE_STA_JOIN  = 3'd3,
      MODE_STA_LEAVE = 3'd4,
      MODE_AP_STOP   = 3'd5,
      MODE_LOST      = 3'd6,
      MODE_GOT_ADDR  = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      LINK_STARTING  = 2'd0,
      LINK_AP_ONLY   = 2'd1,
      LINK_CONNECTED = 2'd2
   } link_type;

   typedef enum logic [1:0] {
      RPT_NONE      = 2'd0,
      RPT_LOST      = 2'd1,
      RPT_JOIN_FAIL = 2'd2
   } report_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STA_WANTED  = 3'd0,
      CSR_STA_ENABLED = 3'd1,
      CSR_BASE_RETRY  = 3'd2,
      CSR_MAX_SHIFT   = 3'd3,
      CSR_QUIET       = 3'd4,
      CSR_SLICE       = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic                 sta_wanted;
      logic                 sta_enabled;
      logic [BASE_W-1:0]    base_retry_ms;
      logic [SHIFT_W-1:0]   max_shift;
      logic [QUIET_W-1:0]   quiet_ms;
      logic [SLICE_W-1:0]   slice_ms;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [REASON_W-1:0]  reason;
      logic [ADDR_W-1:0]    address;
   } item_type;

   // state snapshot after one event, before the status math
   typedef struct packed {
      logic                 connect_now;
      report_type           report;
      logic [REASON_W-1:0]  report_reason;
      link_type             link_state;
      logic [COUNT_W-1:0]   station_count;
      logic [COUNT_W-1:0]   failed_tries;
      logic [ADDR_W-1:0]    upstream_address;
      logic [WAIT_W-1:0]    waited_ms;
   } stat_type;

   typedef struct packed {
      logic                 connect_now;
      report_type           report;
      logic [REASON_W-1:0]  report_reason;
      link_type             link_state;
      logic [COUNT_W-1:0]   station_count;
      logic [COUNT_W-1:0]   failed_tries;
      logic [SECS_W-1:0]    seconds_to_next;
      logic [ADDR_W-1:0]    upstream_address;
   } rsp_type;

   // base << min(tries, max_shift), floored at quiet_ms while stations attached
   function automatic logic [DELAY_W-1:0] backoff_delay(
      input cfg_type            cfg,
      input logic [COUNT_W-1:0] tries,
      input logic [COUNT_W-1:0] stations);
      logic [SHIFT_W-1:0] sh;
      logic [DELAY_W-1:0] ms;
      sh = (tries < {{(COUNT_W-SHIFT_W){1'b0}}, cfg.max_shift}) ?
           tries[SHIFT_W-1:0] : cfg.max_shift;
      ms = {{(DELAY_W-BASE_W){1'b0}}, cfg.base_retry_ms} << sh;
      if ((stations != '0) && (ms < cfg.quiet_ms)) begin
         ms = cfg.quiet_ms;
      end
      return ms;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lrbs_if.sv =====
// Channel interfaces: event requests, status responses and register writes.
// Depends on lrbs_pkg for field widths.
`default_nettype none

interface lrbs_req_if import lrbs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [REASON_W-1:0] reason;
   logic [ADDR_W-1:0]   address;

   modport source (output valid, mode, reason, address, input ready);
   modport sink   (input valid, mode, reason, address, output ready);
endinterface

interface lrbs_rsp_if import lrbs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                connect_now;
   logic [1:0]          report;
   logic [REASON_W-1:0] report_reason;
   logic [1:0]          link_state;
   logic [COUNT_W-1:0]  station_count;
   logic [COUNT_W-1:0]  failed_tries;
   logic [SECS_W-1:0]   seconds_to_next;
   logic [ADDR_W-1:0]   upstream_address;

   modport source (output valid, connect_now, report, report_reason, link_state,
                   station_count, failed_tries, seconds_to_next, upstream_address,
                   input ready);
   modport sink   (input valid, connect_now, report, report_reason, link_state,
                   station_count, failed_tries, seconds_to_next, upstream_address,
                   output ready);
endinterface

interface lrbs_csr_if import lrbs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [CSR_DAT_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lrbs_cfg.sv =====
// Configuration register bank, written through the csr channel.
// Depends on lrbs_pkg and lrbs_csr_if.
`default_nettype none

module lrbs_cfg import lrbs_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   lrbs_csr_if.sink    csr_bus,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_idx_type'(csr_bus.reg_index))
            CSR_STA_WANTED:  cfg_in.sta_wanted    = csr_bus.wdata[0];
            CSR_STA_ENABLED: cfg_in.sta_enabled   = csr_bus.wdata[0];
            CSR_BASE_RETRY:  cfg_in.base_retry_ms = csr_bus.wdata[BASE_W-1:0];
            CSR_MAX_SHIFT:   cfg_in.max_shift     = csr_bus.wdata[SHIFT_W-1:0];
            CSR_QUIET:       cfg_in.quiet_ms      = csr_bus.wdata[QUIET_W-1:0];
            CSR_SLICE:       cfg_in.slice_ms      = csr_bus.wdata[SLICE_W-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sta_wanted    <= 1'b0;
         cfg_ff.sta_enabled   <= 1'b1;
         cfg_ff.base_retry_ms <= BASE_RESET;
         cfg_ff.max_shift     <= SHIFT_RESET;
         cfg_ff.quiet_ms      <= QUIET_RESET;
         cfg_ff.slice_ms      <= SLICE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lrbs_core.sv =====
// Event decode and supervisor state: link mode, stations, tries, wait time,
// force flag, held failure reason and address. Registers the post-event snapshot.
// Depends on lrbs_pkg.
`default_nettype none

module lrbs_core import lrbs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output stat_type      stat
);

   link_type            link_ff,       link_in;
   logic [COUNT_W-1:0]  stations_ff,   stations_in;
   logic [COUNT_W-1:0]  tries_ff,      tries_in;
   logic [WAIT_W-1:0]   waited_ff,     waited_in;
   logic                force_ff,      force_in;
   logic                fail_seen_ff,  fail_seen_in;
   logic [REASON_W-1:0] fail_code_ff,  fail_code_in;
   logic [ADDR_W-1:0]   held_addr_ff,  held_addr_in;
   stat_type            stat_ff,       stat_in;

   logic [WAIT_W:0]     waited_sum;
   logic [DELAY_W-1:0]  delay;
   logic                may_join;
   logic                connect;
   report_type          report;
   logic [REASON_W-1:0] rep_reason;

   assign stat = stat_ff;

   always_comb begin
      link_in      = link_ff;
      stations_in  = stations_ff;
      tries_in     = tries_ff;
      waited_in    = waited_ff;
      force_in     = force_ff;
      fail_seen_in = fail_seen_ff;
      fail_code_in = fail_code_ff;
      held_addr_in = held_addr_ff;
      connect      = 1'b0;
      report       = RPT_NONE;
      rep_reason   = '0;

      waited_sum = {1'b0, waited_ff} + {{(WAIT_W+1-SLICE_W){1'b0}}, cfg.slice_ms};
      delay      = backoff_delay(cfg, tries_ff, stations_ff);
      may_join   = cfg.sta_wanted && cfg.sta_enabled && (link_ff != LINK_CONNECTED);

      case (mode_type'(item.mode))
         MODE_TICK: begin
            waited_in = waited_sum[WAIT_W] ? '1 : waited_sum[WAIT_W-1:0];
            if (may_join &&
                (force_ff || (waited_in >= {{(WAIT_W-DELAY_W){1'b0}}, delay}))) begin
               force_in  = 1'b0;
               waited_in = '0;
               tries_in  = (tries_ff == '1) ? tries_ff : tries_ff + 1'b1;
               connect   = 1'b1;
            end
         end
         MODE_WAKE: begin
            // wake clears tries and forces, so a permitted join always goes out
            if (may_join) begin
               force_in  = 1'b0;
               waited_in = '0;
               tries_in  = {{(COUNT_W-1){1'b0}}, 1'b1};
               connect   = 1'b1;
            end else begin
               force_in  = 1'b1;
               tries_in  = '0;
            end
         end
         MODE_AP_START: begin
            if (link_ff != LINK_CONNECTED) begin
               link_in = LINK_AP_ONLY;
            end
         end
         MODE_STA_JOIN: begin
            if (stations_ff != '1) begin
               stations_in = stations_ff + 1'b1;
            end
         end
         MODE_STA_LEAVE: begin
            if (stations_ff != '0) begin
               stations_in = stations_ff - 1'b1;
            end
         end
         MODE_AP_STOP: ;
         MODE_LOST: begin
            held_addr_in = '0;
            if (link_ff == LINK_CONNECTED) begin
               link_in = LINK_AP_ONLY;
               if (cfg.sta_enabled) begin
                  report     = RPT_LOST;
                  rep_reason = item.reason;
               end
            end else if (cfg.sta_wanted && cfg.sta_enabled &&
                         (!fail_seen_ff || (item.reason != fail_code_ff))) begin
               // report a join failure only when its reason differs from the last one held
               fail_seen_in = 1'b1;
               fail_code_in = item.reason;
               report       = RPT_JOIN_FAIL;
               rep_reason   = item.reason;
            end
         end
         MODE_GOT_ADDR: begin
            held_addr_in = item.address;
            link_in      = LINK_CONNECTED;
            fail_seen_in = 1'b0;
            tries_in     = '0;
         end
         default: ;
      endcase

      stat_in.connect_now      = connect;
      stat_in.report           = report;
      stat_in.report_reason    = rep_reason;
      stat_in.link_state       = link_in;
      stat_in.station_count    = stations_in;
      stat_in.failed_tries     = tries_in;
      stat_in.upstream_address = held_addr_in;
      stat_in.waited_ms        = waited_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff      <= LINK_STARTING;
         stations_ff  <= '0;
         tries_ff     <= '0;
         waited_ff    <= '0;
         force_ff     <= 1'b1;
         fail_seen_ff <= 1'b0;
         fail_code_ff <= '0;
         held_addr_ff <= '0;
      end else if (advance) begin
         link_ff      <= link_in;
         stations_ff  <= stations_in;
         tries_ff     <= tries_in;
         waited_ff    <= waited_in;
         force_ff     <= force_in;
         fail_seen_ff <= fail_seen_in;
         fail_code_ff <= fail_code_in;
         held_addr_ff <= held_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stat_ff <= stat_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lrbs_status.sv =====
// Status math: next delay and remaining ms, then whole seconds by a
// reciprocal multiply. Two payload stages ending in the response register.
// Depends on lrbs_pkg.
`default_nettype none

module lrbs_status import lrbs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     load_remain,
   input  wire logic     load_out,
   input  wire stat_type stat,
   input  wire cfg_type  cfg,
   output rsp_type       rsp
);

   logic [DELAY_W-1:0] delay;
   logic [DELAY_W-1:0] remain_ff, remain_in;
   rsp_type            mid_ff,    mid_in;
   rsp_type            out_ff,    out_in;
   logic [PROD_W-1:0]  prod;

   assign rsp = out_ff;

   always_comb begin
      delay = backoff_delay(cfg, stat.failed_tries, stat.station_count);
      // delay is narrower than waited, so any positive gap fits in DELAY_W
      if ({{(WAIT_W-DELAY_W){1'b0}}, delay} > stat.waited_ms) begin
         remain_in = delay - stat.waited_ms[DELAY_W-1:0];
      end else begin
         remain_in = '0;
      end

      mid_in.connect_now      = stat.connect_now;
      mid_in.report           = stat.report;
      mid_in.report_reason    = stat.report_reason;
      mid_in.link_state       = stat.link_state;
      mid_in.station_count    = stat.station_count;
      mid_in.failed_tries     = stat.failed_tries;
      mid_in.seconds_to_next  = '0;
      mid_in.upstream_address = stat.upstream_address;
   end

   always_comb begin
      prod   = {{MUL_W{1'b0}}, remain_ff} * {{DELAY_W{1'b0}}, DIV_MUL};
      out_in = mid_ff;
      out_in.seconds_to_next = prod[DIV_SHIFT +: SECS_W];
   end

   always_ff @(posedge clock) begin
      if (load_remain) begin
         remain_ff <= remain_in;
         mid_ff    <= mid_in;
      end
      if (load_out) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/link_retry_backoff_supervisor.sv =====
// Top level of the link retry backoff supervisor: input register, stage
// valid bits and flow control around lrbs_cfg, lrbs_core and lrbs_status.
// Depends on lrbs_pkg and the lrbs_*_if interfaces.
//
//   channel  | dir | beat carries
//   ---------+-----+-------------------------------------------------------
//   req_bus  | in  | mode, reason, address (one event)
//   rsp_bus  | out | connect_now, report, report_reason, link_state,
//            |     | station_count, failed_tries, seconds_to_next, address
//   csr_bus  | in  | reg_index, wdata (register write, always ready)
//
// One event per cycle sustained while rsp_bus does not stall; each event
// passes input reg -> state update -> remain -> seconds multiply.
// The state update loop in lrbs_core sets the rate.
// Reset loads cfg and state defaults, clears valid bits; no clearing pass.
// A stalled response backs up through the four stage registers, after
// which req_bus.ready drops.
`default_nettype none

module link_retry_backoff_supervisor import lrbs_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   lrbs_req_if.sink    req_bus,
   lrbs_rsp_if.source  rsp_bus,
   lrbs_csr_if.sink    csr_bus
);

   cfg_type  cfg;
   item_type item_ff;
   stat_type stat;
   rsp_type  rsp;

   logic in_valid_ff,  in_valid_in;
   logic st_valid_ff,  st_valid_in;
   logic mid_valid_ff, mid_valid_in;
   logic out_valid_ff, out_valid_in;

   logic out_free, mid_free, st_free, in_free;
   logic in_adv, st_adv, mid_adv, req_fire;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign mid_free = !mid_valid_ff || out_free;
   assign st_free  = !st_valid_ff  || mid_free;
   assign in_free  = !in_valid_ff  || st_free;

   assign in_adv   = in_valid_ff  && st_free;
   assign st_adv   = st_valid_ff  && mid_free;
   assign mid_adv  = mid_valid_ff && out_free;
   assign req_fire = req_bus.valid && in_free;

   assign req_bus.ready = in_free;

   always_comb begin
      in_valid_in  = req_fire || (in_valid_ff  && !in_adv);
      st_valid_in  = in_adv   || (st_valid_ff  && !st_adv);
      mid_valid_in = st_adv   || (mid_valid_ff && !mid_adv);
      out_valid_in = mid_adv  || (out_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         st_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         st_valid_ff  <= st_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.mode    <= req_bus.mode;
         item_ff.reason  <= req_bus.reason;
         item_ff.address <= req_bus.address;
      end
   end

   lrbs_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   lrbs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (in_adv),
      .item    (item_ff),
      .cfg     (cfg),
      .stat    (stat)
   );

   lrbs_status u_status (
      .clock       (clock),
      .load_remain (st_adv),
      .load_out    (mid_adv),
      .stat        (stat),
      .cfg         (cfg),
      .rsp         (rsp)
   );

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.connect_now      = rsp.connect_now;
   assign rsp_bus.report           = rsp.report;
   assign rsp_bus.report_reason    = rsp.report_reason;
   assign rsp_bus.link_state       = rsp.link_state;
   assign rsp_bus.station_count    = rsp.station_count;
   assign rsp_bus.failed_tries     = rsp.failed_tries;
   assign rsp_bus.seconds_to_next  = rsp.seconds_to_next;
   assign rsp_bus.upstream_address = rsp.upstream_address;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for link_retry_backoff_supervisor: a directed table, saturation bursts,
// then random event phases with register retuning, checked vs golden rows or a predictor.
// Depends on lrbs_pkg, the lrbs_*_if interfaces and the RTL top level.
`timescale 1ns / 100ps

module tb;
   import lrbs_pkg::*;

   localparam int          RANDOM_ITEMS = 500;
   localparam int          MS_PER_SEC   = 1000;
   localparam logic [2:0]  CSR_SPARE_LO = 3'd6;
   localparam logic [2:0]  CSR_SPARE_HI = 3'd7;

   typedef enum logic { ROW_EVENT, ROW_WRITE } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      item_type              ev;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DAT_W-1:0]  wdata;
      logic                  typed;
      rsp_type               golden;
   } row_type;

   logic clock;
   logic reset;

   lrbs_req_if req_bus ();
   lrbs_rsp_if rsp_bus ();
   lrbs_csr_if csr_bus ();

   link_retry_backoff_supervisor u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predictor state
   cfg_type              cfg;
   link_type             cur_link;
   logic [COUNT_W-1:0]   cur_stations;
   logic [COUNT_W-1:0]   cur_tries;
   logic [WAIT_W-1:0]    cur_waited;
   logic                 join_forced;
   logic                 fail_held;
   logic [REASON_W-1:0]  fail_reason;
   logic [ADDR_W-1:0]    cur_address;

   rsp_type  status_q[$];
   row_type  plan[$];
   int       mismatch_count = 0;
   logic     full_rate = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12_000_000);
      $display("TB_ERROR");
      $finish;
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? int'($urandom_range(12, 40))
                                         : int'($urandom_range(1, 3));
   endfunction

   function automatic logic [31:0] next_due_ms();
      logic [2:0]  sh;
      logic [31:0] ms;
      sh = (cur_tries < {5'd0, cfg.max_shift}) ? cur_tries[2:0] : cfg.max_shift;
      ms = {16'd0, cfg.base_retry_ms} << sh;
      if (cur_stations != '0 && ms < {8'd0, cfg.quiet_ms}) begin
         ms = {8'd0, cfg.quiet_ms};
      end
      return ms;
   endfunction

   function automatic logic try_join();
      if (cfg.sta_wanted && cfg.sta_enabled && cur_link != LINK_CONNECTED &&
          (join_forced || cur_waited >= next_due_ms())) begin
         join_forced = 1'b0;
         cur_waited  = '0;
         if (cur_tries != 8'hFF) cur_tries = cur_tries + 8'd1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // applies one event to the predictor state and returns the status beat it causes
   function automatic rsp_type next_status(input item_type ev);
      rsp_type     r;
      logic [31:0] due;
      logic [31:0] remain;
      r = '0;
      case (ev.mode)
         MODE_TICK: begin
            if (cur_waited > 32'hFFFF_FFFF - {16'd0, cfg.slice_ms}) cur_waited = '1;
            else cur_waited = cur_waited + {16'd0, cfg.slice_ms};
            r.connect_now = try_join();
         end
         MODE_WAKE: begin
            cur_tries   = '0;
            join_forced = 1'b1;
            r.connect_now = try_join();
         end
         MODE_AP_START: begin
            if (cur_link != LINK_CONNECTED) cur_link = LINK_AP_ONLY;
         end
         MODE_STA_JOIN: begin
            if (cur_stations != 8'hFF) cur_stations = cur_stations + 8'd1;
         end
         MODE_STA_LEAVE: begin
            if (cur_stations != 8'h00) cur_stations = cur_stations - 8'd1;
         end
         MODE_AP_STOP: ;
         MODE_LOST: begin
            cur_address = '0;
            if (cur_link == LINK_CONNECTED) begin
               cur_link = LINK_AP_ONLY;
               if (cfg.sta_enabled) begin
                  r.report        = RPT_LOST;
                  r.report_reason = ev.reason;
               end
            end else if (cfg.sta_wanted && cfg.sta_enabled &&
                         (!fail_held || ev.reason != fail_reason)) begin
               // a repeat of the last reported failure reason is not reported again
               fail_held       = 1'b1;
               fail_reason     = ev.reason;
               r.report        = RPT_JOIN_FAIL;
               r.report_reason = ev.reason;
            end
         end
         MODE_GOT_ADDR: begin
            cur_address = ev.address;
            cur_link    = LINK_CONNECTED;
            fail_held   = 1'b0;
            cur_tries   = '0;
         end
         default: ;
      endcase
      due    = next_due_ms();
      remain = (due > cur_waited) ? due - cur_waited : 32'd0;
      r.link_state       = cur_link;
      r.station_count    = cur_stations;
      r.failed_tries     = cur_tries;
      r.seconds_to_next  = 15'(remain / MS_PER_SEC);
      r.upstream_address = cur_address;
      return r;
   endfunction

   function automatic row_type ev_row(input mode_type m, input logic [7:0] rs,
                                      input logic [31:0] ad);
      row_type r;
      r            = '0;
      r.kind       = ROW_EVENT;
      r.ev.mode    = m;
      r.ev.reason  = rs;
      r.ev.address = ad;
      return r;
   endfunction

   function automatic row_type golden_row(input mode_type m, input logic [7:0] rs,
                                          input logic [31:0] ad, input rsp_type g);
      row_type r;
      r        = ev_row(m, rs, ad);
      r.typed  = 1'b1;
      r.golden = g;
      return r;
   endfunction

   function automatic row_type write_row(input logic [2:0] idx, input logic [23:0] d);
      row_type r;
      r         = '0;
      r.kind    = ROW_WRITE;
      r.reg_idx = idx;
      r.wdata   = d;
      return r;
   endfunction

   // drop valid if still up, then wait for every pending status beat
   task automatic wait_idle();
      if (req_bus.valid) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      while (status_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [23:0] data);
      wait_idle();
      @(negedge clock);
      csr_bus.valid     = 1'b1;
      csr_bus.reg_index = idx;
      csr_bus.wdata     = data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_STA_WANTED:  cfg.sta_wanted    = data[0];
         CSR_STA_ENABLED: cfg.sta_enabled   = data[0];
         CSR_BASE_RETRY:  cfg.base_retry_ms = data[15:0];
         CSR_MAX_SHIFT:   cfg.max_shift     = data[2:0];
         CSR_QUIET:       cfg.quiet_ms      = data;
         CSR_SLICE:       cfg.slice_ms      = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic send_event(input item_type ev, input int gap, input logic typed,
                             input rsp_type golden);
      rsp_type predicted;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid   = 1'b1;
      req_bus.mode    = ev.mode;
      req_bus.reason  = ev.reason;
      req_bus.address = ev.address;
      do @(posedge clock); while (!req_bus.ready);
      predicted = next_status(ev);
      status_q.push_back(typed ? golden : predicted);
   endtask

   task automatic send_burst(input mode_type m, input int n);
      item_type ev;
      repeat (n) begin
         ev.mode    = m;
         ev.reason  = 8'($urandom);
         ev.address = $urandom;
         send_event(ev, 0, 1'b0, '0);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // response side: random stalls unless a full-rate stretch is running
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (full_rate || $urandom_range(0, 3) != 0) begin
            rsp_bus.ready = 1'b1;
         end else begin
            rsp_bus.ready = 1'b0;
            repeat (gap_len() - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (status_q.size() == 0) begin
            mismatch_count++;
            $display("%0t status beat with nothing pending: expected none actual %0h",
                     $time, rsp_bus.upstream_address);
         end else begin
            want = status_q.pop_front();
            check_field("connect_now", 32'(want.connect_now), 32'(rsp_bus.connect_now));
            check_field("report", 32'(want.report), 32'(rsp_bus.report));
            check_field("report_reason", 32'(want.report_reason),
                        32'(rsp_bus.report_reason));
            check_field("link_state", 32'(want.link_state), 32'(rsp_bus.link_state));
            check_field("station_count", 32'(want.station_count),
                        32'(rsp_bus.station_count));
            check_field("failed_tries", 32'(want.failed_tries),
                        32'(rsp_bus.failed_tries));
            check_field("seconds_to_next", 32'(want.seconds_to_next),
                        32'(rsp_bus.seconds_to_next));
            check_field("upstream_address", want.upstream_address,
                        rsp_bus.upstream_address);
         end
      end
   end

   initial begin
      item_type    ev;
      logic [23:0] wd;
      int          random_sent;
      int          n_items;
      int          r;
      int          gap;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.mode      = '0;
      req_bus.reason    = '0;
      req_bus.address   = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.reg_index = '0;
      csr_bus.wdata     = '0;

      cfg.sta_wanted    = 1'b0;
      cfg.sta_enabled   = 1'b1;
      cfg.base_retry_ms = BASE_RESET;
      cfg.max_shift     = SHIFT_RESET;
      cfg.quiet_ms      = QUIET_RESET;
      cfg.slice_ms      = SLICE_RESET;
      cur_link          = LINK_STARTING;
      cur_stations      = '0;
      cur_tries         = '0;
      cur_waited        = '0;
      join_forced       = 1'b1;
      fail_held         = 1'b0;
      fail_reason       = '0;
      cur_address       = '0;

      // golden columns: connect, report, reason, link, stations, tries, secs, address
      plan.push_back(golden_row(MODE_TICK, 8'h00, 32'h0,
         {1'b0, RPT_NONE, 8'h00, LINK_STARTING, 8'd0, 8'd0, 15'd25, 32'h0}));
      plan.push_back(golden_row(MODE_LOST, 8'h08, 32'h0,
         {1'b0, RPT_NONE, 8'h00, LINK_STARTING, 8'd0, 8'd0, 15'd25, 32'h0}));
      plan.push_back(write_row(CSR_STA_WANTED, 24'h000001));
      plan.push_back(golden_row(MODE_WAKE, 8'h00, 32'h0,
         {1'b1, RPT_NONE, 8'h00, LINK_STARTING, 8'd0, 8'd1, 15'd60, 32'h0}));
      plan.push_back(ev_row(MODE_TICK, 8'h00, 32'h0));
      plan.push_back(ev_row(MODE_AP_START, 8'h00, 32'h0));
      plan.push_back(ev_row(MODE_STA_JOIN, 8'h00, 32'h0));
      plan.push_back(ev_row(MODE_STA_JOIN, 8'h00, 32'h0));
      plan.push_back(ev_row(MODE_STA_LEAVE, 8'h00, 32'h0));
      plan.push_back(ev_row(MODE_LOST, 8'h00, 32'h0));
      plan.push_back(ev_row(MODE_LOST, 8'h00, 32'h0));   // repeated reason stays quiet
      plan.push_back(ev_row(MODE_LOST, 8'hFF, 32'h0));
      plan.push_back(ev_row(MODE_AP_STOP, 8'h00, 32'h0));
      plan.push_back(ev_row(MODE_GOT_ADDR, 8'h00, 32'hFFFF_FFFF));
      plan.push_back(ev_row(MODE_TICK, 8'h00, 32'h0));
      plan.push_back(ev_row(MODE_LOST, 8'hAB, 32'h0));
      plan.push_back(ev_row(MODE_GOT_ADDR, 8'h00, 32'h8000_0001));
      plan.push_back(write_row(CSR_STA_ENABLED, 24'hFFFFFE));  // upper bits masked
      plan.push_back(ev_row(MODE_LOST, 8'h55, 32'h0));
      plan.push_back(ev_row(MODE_WAKE, 8'h00, 32'h0));
      plan.push_back(write_row(CSR_STA_ENABLED, 24'h000001));
      plan.push_back(write_row(CSR_BASE_RETRY, 24'h000000));
      plan.push_back(write_row(CSR_QUIET, 24'h000000));
      plan.push_back(ev_row(MODE_TICK, 8'h00, 32'h0));   // zero delay joins at once
      plan.push_back(ev_row(MODE_STA_LEAVE, 8'h00, 32'h0));
      plan.push_back(ev_row(MODE_STA_LEAVE, 8'h00, 32'h0));
      plan.push_back(write_row(CSR_BASE_RETRY, 24'h00FFFF));
      plan.push_back(write_row(CSR_MAX_SHIFT, 24'h000007));
      plan.push_back(write_row(CSR_QUIET, 24'hFFFFFF));
      plan.push_back(write_row(CSR_SLICE, 24'h00FFFF));
      plan.push_back(ev_row(MODE_WAKE, 8'h00, 32'h0));
      plan.push_back(ev_row(MODE_STA_JOIN, 8'h00, 32'h0));
      plan.push_back(ev_row(MODE_TICK, 8'h00, 32'h0));
      plan.push_back(write_row(CSR_SPARE_LO, 24'hFFFFFF));
      plan.push_back(write_row(CSR_SPARE_HI, 24'h5A5A5A));
      plan.push_back(ev_row(MODE_GOT_ADDR, 8'h00, 32'h1234_5678));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            csr_write(plan[i].reg_idx, plan[i].wdata);
         end else begin
            gap = $urandom_range(0, 1) ? gap_len() : 0;
            send_event(plan[i].ev, gap, plan[i].typed, plan[i].golden);
         end
      end

      // saturation: tries at zero delay, station count both ways, then a long wait
      full_rate = 1'b1;
      csr_write(CSR_BASE_RETRY, 24'h000000);
      csr_write(CSR_QUIET, 24'h000000);
      send_burst(MODE_LOST, 1);
      send_burst(MODE_TICK, 260);
      send_burst(MODE_STA_JOIN, 258);
      send_burst(MODE_STA_LEAVE, 258);
      csr_write(CSR_STA_WANTED, 24'h000000);
      csr_write(CSR_BASE_RETRY, 24'h00FFFF);
      csr_write(CSR_SLICE, 24'h00FFFF);
      send_burst(MODE_STA_JOIN, 1);
      send_burst(MODE_TICK, 20);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         full_rate = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) != 0) begin
            if ($urandom_range(0, 1)) begin
               wd    = 24'($urandom);
               wd[0] = ($urandom_range(0, 4) != 0);
               csr_write(CSR_STA_WANTED, wd);
            end
            if ($urandom_range(0, 1)) begin
               wd    = 24'($urandom);
               wd[0] = ($urandom_range(0, 6) != 0);
               csr_write(CSR_STA_ENABLED, wd);
            end
            if ($urandom_range(0, 1)) begin
               wd = 24'($urandom);
               case ($urandom_range(0, 9))
                  0:       wd[15:0] = 16'h0000;
                  1:       wd[15:0] = 16'hFFFF;
                  2:       wd[15:0] = 16'h0001;
                  3, 4, 5: wd[15:0] = 16'($urandom_range(1, 3000));
                  default: ;
               endcase
               csr_write(CSR_BASE_RETRY, wd);
            end
            if ($urandom_range(0, 1)) csr_write(CSR_MAX_SHIFT, 24'($urandom));
            if ($urandom_range(0, 1)) begin
               case ($urandom_range(0, 7))
                  0:       wd = 24'h000000;
                  1:       wd = 24'hFFFFFF;
                  2, 3, 4: wd = 24'($urandom_range(0, 200000));
                  default: wd = 24'($urandom);
               endcase
               csr_write(CSR_QUIET, wd);
            end
            if ($urandom_range(0, 1)) begin
               wd = 24'($urandom);
               case ($urandom_range(0, 11))
                  0:       wd[15:0] = 16'h0000;
                  1:       wd[15:0] = 16'hFFFF;
                  2:       wd[15:0] = 16'h0001;
                  default: wd[15:0] = 16'($urandom_range(500, 65535));
               endcase
               csr_write(CSR_SLICE, wd);
            end
            if ($urandom_range(0, 7) == 0)
               csr_write($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, 24'($urandom));
         end

         n_items = $urandom_range(30, 90);
         repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < 40)      ev.mode = MODE_TICK;
            else if (r < 48) ev.mode = MODE_WAKE;
            else if (r < 54) ev.mode = MODE_AP_START;
            else if (r < 66) ev.mode = MODE_STA_JOIN;
            else if (r < 77) ev.mode = MODE_STA_LEAVE;
            else if (r < 81) ev.mode = MODE_AP_STOP;
            else if (r < 92) ev.mode = MODE_LOST;
            else             ev.mode = MODE_GOT_ADDR;
            // a few recurring reasons so repeated failures get exercised
            ev.reason = $urandom_range(0, 1) ? 8'($urandom_range(0, 2) * 7 + 2)
                                             : 8'($urandom);
            case ($urandom_range(0, 7))
               0:       ev.address = 32'h0000_0000;
               1:       ev.address = 32'hFFFF_FFFF;
               default: ev.address = $urandom;
            endcase
            gap = (!full_rate && $urandom_range(0, 2) == 0) ? gap_len() : 0;
            send_event(ev, gap, 1'b0, '0);
            if ($urandom_range(0, 150) == 0) wait_idle();
         end
         random_sent += n_items;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/lrbs_pkg.sv
rtl/core/lrbs_if.sv
rtl/core/lrbs_cfg.sv
rtl/core/lrbs_core.sv
rtl/core/lrbs_status.sv
rtl/core/link_retry_backoff_supervisor.sv
dv/tb.sv
